/* hdl/battery_relay_sequencer_top_assert.svh */
// Assertion macros for the battery relay sequencer.
// Each macro uses clk and rst_n from the including module.
`ifndef BATTERY_RELAY_SEQUENCER_TOP_ASSERT_SVH
`define BATTERY_RELAY_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brs assertion failed");

// Next-cycle implication, checked outside reset.
`define BRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brs assertion failed");

`endif

/* hdl/brs_pkg.sv */
// Shared types and constants for the battery relay sequencer.
// No dependencies; imported by all modules of the block.
`timescale 1ns / 1ps

package brs_pkg;

  localparam int unsigned DelayW  = 16;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned BitSelW = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [DelayW-1:0]  StepDelayRst = 16'd100;
  localparam logic [BitSelW-1:0] RelayBitRst  = 4'd0;

  localparam logic [CfgIdxW-1:0] CFG_STEP_DELAY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELAY_BIT  = 2'd1;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_SENSE = 2'd2,
    KIND_FAULT = 2'd3
  } kind_t;

  typedef struct packed {
    logic [DelayW-1:0]  step_delay_ms;
    logic [BitSelW-1:0] battery_relay_bit;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [MaskW-1:0]  cmd_sel;
    logic              relay_close;
    logic              hv_sensed;
    logic              gnd_sensed;
    logic              charging;
  } item_t;

  typedef struct packed {
    logic hv_drive;
    logic gnd_drive;
    logic open_gnd_first;
    logic report_state;
    logic report_hv;
    logic report_gnd;
    logic confirm_battery;
    logic busy_res;
  } result_t;

endpackage

/* hdl/brs_cfg.sv */
// Configuration registers of the battery relay sequencer.
// Depends on brs_pkg for the register index codes and cfg_t.
`timescale 1ns / 1ps

module brs_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [brs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [brs_pkg::DelayW-1:0]   cfg_wdata,
  output brs_pkg::cfg_t                cfg
);
  import brs_pkg::*;

  logic [DelayW-1:0]  step_delay_r;
  logic [BitSelW-1:0] relay_bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_delay_r <= StepDelayRst;
      relay_bit_r  <= RelayBitRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_DELAY: step_delay_r <= cfg_wdata;
        CFG_RELAY_BIT:  relay_bit_r  <= cfg_wdata[BitSelW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  assign cfg.step_delay_ms     = step_delay_r;
  assign cfg.battery_relay_bit = relay_bit_r;

endmodule

/* hdl/brs_core.sv */
// Relay sequencing state and per-item result logic.
// Depends on brs_pkg and the assertion macros header.
`timescale 1ns / 1ps

module brs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  brs_pkg::item_t    item,
  input  brs_pkg::cfg_t     cfg,
  output brs_pkg::result_t  res
);
  import brs_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_WAIT_HV      = 2'd1,
    PH_WAIT_CONFIRM = 2'd2,
    PH_WAIT_REPORT  = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [DelayW-1:0] countdown_r, countdown_nxt;
  logic              hv_drive_r, hv_drive_nxt;
  logic              gnd_drive_r, gnd_drive_nxt;
  logic              hv_seen_r, hv_seen_nxt;
  logic              gnd_seen_r, gnd_seen_nxt;
  logic              selected;
  logic              step_due;
  logic              fault_taken;

  assign selected    = item.cmd_sel[cfg.battery_relay_bit];
  assign step_due    = (countdown_r <= DelayW'(1));
  assign fault_taken = advance && (item.kind == KIND_FAULT);

  always_comb begin
    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    hv_drive_nxt  = hv_drive_r;
    gnd_drive_nxt = gnd_drive_r;
    hv_seen_nxt   = hv_seen_r;
    gnd_seen_nxt  = gnd_seen_r;
    res           = '0;

    unique case (item.kind)
      KIND_TICK: begin
        if (phase_r != PH_IDLE) begin
          if (step_due) begin
            unique case (phase_r)
              PH_WAIT_HV: begin
                hv_drive_nxt  = 1'b1;
                phase_nxt     = PH_WAIT_CONFIRM;
                countdown_nxt = cfg.step_delay_ms;
              end
              PH_WAIT_CONFIRM: begin
                res.confirm_battery = 1'b1;
                phase_nxt           = PH_IDLE;
                countdown_nxt       = '0;
              end
              default: begin
                res.report_state = 1'b1;
                res.report_hv    = hv_seen_r;
                res.report_gnd   = gnd_seen_r;
                phase_nxt        = PH_IDLE;
                countdown_nxt    = '0;
              end
            endcase
          end else begin
            countdown_nxt = countdown_r - DelayW'(1);
          end
        end
      end
      KIND_CMD: begin
        // a new command replaces whatever step is pending
        if (selected) begin
          if (item.relay_close) begin
            gnd_drive_nxt = 1'b1;
            phase_nxt     = PH_WAIT_HV;
          end else begin
            hv_drive_nxt       = 1'b0;
            gnd_drive_nxt      = 1'b0;
            res.open_gnd_first = item.charging;
            phase_nxt          = PH_WAIT_REPORT;
          end
          countdown_nxt = cfg.step_delay_ms;
        end
      end
      KIND_SENSE: begin
        hv_seen_nxt  = item.hv_sensed;
        gnd_seen_nxt = item.gnd_sensed;
      end
      default: begin
        // fault: open both relays and report right away
        hv_drive_nxt       = 1'b0;
        gnd_drive_nxt      = 1'b0;
        res.open_gnd_first = item.charging;
        phase_nxt          = PH_IDLE;
        countdown_nxt      = '0;
        res.report_state   = 1'b1;
        res.report_hv      = hv_seen_r;
        res.report_gnd     = gnd_seen_r;
      end
    endcase

    res.hv_drive  = hv_drive_nxt;
    res.gnd_drive = gnd_drive_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      countdown_r <= '0;
      hv_drive_r  <= 1'b0;
      gnd_drive_r <= 1'b0;
      hv_seen_r   <= 1'b0;
      gnd_seen_r  <= 1'b0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      countdown_r <= countdown_nxt;
      hv_drive_r  <= hv_drive_nxt;
      gnd_drive_r <= gnd_drive_nxt;
      hv_seen_r   <= hv_seen_nxt;
      gnd_seen_r  <= gnd_seen_nxt;
    end
  end

`include "battery_relay_sequencer_top_assert.svh"

  `BRS_ASSERT_NOW(a_idle_no_count, phase_r == PH_IDLE, countdown_r == '0)
  `BRS_ASSERT_NOW(a_hv_needs_gnd, hv_drive_r, gnd_drive_r)
  `BRS_ASSERT_NOW(a_confirm_hv_on, phase_r == PH_WAIT_CONFIRM, hv_drive_r)
  `BRS_ASSERT_NEXT(a_fault_opens, fault_taken, phase_r == PH_IDLE && !hv_drive_r && !gnd_drive_r)

endmodule

/* hdl/battery_relay_sequencer_top.sv */
// Top level of the battery relay sequencer: input register, core, result register.
// Depends on brs_pkg, brs_cfg and brs_core.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | kind, cmd_sel, close, sensed, charging
//   out_    | output    | out_valid/out_stall | drives, order, report, confirm, busy
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ does not stall; out_valid rises once
// the accepted transaction has moved from the input register into the result register.
// The relay state updates as a transaction moves from the input to the result register.
// Synchronous reset clears the state and both pipeline valids and resets the config.
// Once both registers hold a transaction, a stall on out_ reaches in_stall in the same
// cycle, so no transaction is lost.
`timescale 1ns / 1ps

module battery_relay_sequencer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic [brs_pkg::MaskW-1:0]    in_cmd_sel,
  input  logic                         in_relay_close,
  input  logic                         in_hv_sensed,
  input  logic                         in_gnd_sensed,
  input  logic                         in_charging,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hv_drive,
  output logic                         out_gnd_drive,
  output logic                         out_open_gnd_first,
  output logic                         out_report_state,
  output logic                         out_report_hv,
  output logic                         out_report_gnd,
  output logic                         out_confirm_battery,
  output logic                         out_busy_res,
  input  logic                         cfg_we,
  input  logic [brs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [brs_pkg::DelayW-1:0]   cfg_wdata
);
  import brs_pkg::*;

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r, s1_valid_nxt;
  result_t core_res;
  result_t out_res_r;
  logic    out_valid_r, out_valid_nxt;
  logic    out_free;
  logic    s1_move;
  logic    in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: load only on a transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.kind        <= kind_t'(in_kind);
      s1_item_r.cmd_sel     <= in_cmd_sel;
      s1_item_r.relay_close <= in_relay_close;
      s1_item_r.hv_sensed   <= in_hv_sensed;
      s1_item_r.gnd_sensed  <= in_gnd_sensed;
      s1_item_r.charging    <= in_charging;
    end
    if (s1_move) begin
      out_res_r <= core_res;
    end
  end

  brs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  brs_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_move),
    .item    (s1_item_r),
    .cfg     (cfg),
    .res     (core_res)
  );

  assign out_valid           = out_valid_r;
  assign out_hv_drive        = out_res_r.hv_drive;
  assign out_gnd_drive       = out_res_r.gnd_drive;
  assign out_open_gnd_first  = out_res_r.open_gnd_first;
  assign out_report_state    = out_res_r.report_state;
  assign out_report_hv       = out_res_r.report_hv;
  assign out_report_gnd      = out_res_r.report_gnd;
  assign out_confirm_battery = out_res_r.confirm_battery;
  assign out_busy_res        = out_res_r.busy_res;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for battery_relay_sequencer_top: a directed stimulus table,
// then random relay sequences, scored against table rows or an in-bench predictor.
// Depends on brs_pkg and the RTL of the block.

module tb;
  import brs_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_WAIT_HV,
    SEQ_WAIT_CONFIRM,
    SEQ_WAIT_REPORT
  } seq_phase_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t              op;
    item_t                it;
    logic [CfgIdxW-1:0]   idx;
    logic [DelayW-1:0]    wdata;
    bit                   has_exp;
    result_t              exp;
  } stim_row_t;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;
  localparam int unsigned LONG_HOLD = 60;
  localparam int unsigned N_SETTINGS = 8;
  localparam string FIELD_NAMES [8] = '{"busy_res", "confirm_battery", "report_gnd",
                                         "report_hv", "report_state", "open_gnd_first",
                                         "gnd_drive", "hv_drive"};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_kind;
  logic [MaskW-1:0]    in_cmd_sel;
  logic                in_relay_close;
  logic                in_hv_sensed;
  logic                in_gnd_sensed;
  logic                in_charging;
  logic                out_valid;
  logic                out_stall;
  logic                out_hv_drive;
  logic                out_gnd_drive;
  logic                out_open_gnd_first;
  logic                out_report_state;
  logic                out_report_hv;
  logic                out_report_gnd;
  logic                out_confirm_battery;
  logic                out_busy_res;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [DelayW-1:0]   cfg_wdata;

  battery_relay_sequencer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_cmd_sel          (in_cmd_sel),
    .in_relay_close      (in_relay_close),
    .in_hv_sensed        (in_hv_sensed),
    .in_gnd_sensed       (in_gnd_sensed),
    .in_charging         (in_charging),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hv_drive        (out_hv_drive),
    .out_gnd_drive       (out_gnd_drive),
    .out_open_gnd_first  (out_open_gnd_first),
    .out_report_state    (out_report_state),
    .out_report_hv       (out_report_hv),
    .out_report_gnd      (out_report_gnd),
    .out_confirm_battery (out_confirm_battery),
    .out_busy_res        (out_busy_res),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // Relay sequence predictor state and register mirror
  seq_phase_t          seq_phase = SEQ_IDLE;
  logic [DelayW-1:0]   seq_count = '0;
  logic                hv_on = 1'b0;
  logic                gnd_on = 1'b0;
  logic                hv_seen = 1'b0;
  logic                gnd_seen = 1'b0;
  logic [DelayW-1:0]   step_delay = StepDelayRst;
  logic [BitSelW-1:0]  relay_bit = RelayBitRst;

  result_t             relay_exp_q [$];
  stim_row_t           dir_tab [$];
  int unsigned         err_cnt = 0;
  int unsigned         items_sent = 0;
  int unsigned         results_seen = 0;
  int unsigned         confirms_seen = 0;
  int unsigned         reports_seen = 0;
  int unsigned         rx_hold_len = 0;
  bit                  rx_quiet = 1'b0;
  bit                  tx_quiet = 1'b0;

  logic [DelayW-1:0]   set_delay [N_SETTINGS] = '{16'd1, 16'd2, 16'd3, 16'd0,
                                                  16'd5, 16'hFFFF, 16'd4, 16'd1};
  logic [BitSelW-1:0]  set_bit [N_SETTINGS] = '{4'd0, 4'd15, 4'd7, 4'd3,
                                                4'd9, 4'd15, 4'd12, 4'd5};
  int unsigned         set_budget [N_SETTINGS] = '{200, 200, 200, 180, 200, 60, 200, 190};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t relay_predict(input item_t it);
    result_t r;
    r = '0;
    case (it.kind)
      KIND_TICK: begin
        if (seq_phase != SEQ_IDLE) begin
          if (seq_count <= 16'd1) begin
            case (seq_phase)
              SEQ_WAIT_HV: begin
                hv_on = 1'b1;
                seq_phase = SEQ_WAIT_CONFIRM;
                seq_count = step_delay;
              end
              SEQ_WAIT_CONFIRM: begin
                r.confirm_battery = 1'b1;
                seq_phase = SEQ_IDLE;
                seq_count = '0;
              end
              default: begin
                r.report_state = 1'b1;
                r.report_hv = hv_seen;
                r.report_gnd = gnd_seen;
                seq_phase = SEQ_IDLE;
                seq_count = '0;
              end
            endcase
          end else begin
            seq_count = seq_count - 16'd1;
          end
        end
      end
      KIND_CMD: begin
        if (it.cmd_sel[relay_bit]) begin
          if (it.relay_close) begin
            gnd_on = 1'b1;
            seq_phase = SEQ_WAIT_HV;
          end else begin
            hv_on = 1'b0;
            gnd_on = 1'b0;
            r.open_gnd_first = it.charging;
            seq_phase = SEQ_WAIT_REPORT;
          end
          // a new command replaces whatever step was pending
          seq_count = step_delay;
        end
      end
      KIND_SENSE: begin
        hv_seen = it.hv_sensed;
        gnd_seen = it.gnd_sensed;
      end
      default: begin
        hv_on = 1'b0;
        gnd_on = 1'b0;
        r.open_gnd_first = it.charging;
        seq_phase = SEQ_IDLE;
        seq_count = '0;
        r.report_state = 1'b1;
        r.report_hv = hv_seen;
        r.report_gnd = gnd_seen;
      end
    endcase
    r.hv_drive = hv_on;
    r.gnd_drive = gnd_on;
    r.busy_res = (seq_phase != SEQ_IDLE);
    return r;
  endfunction

  function automatic item_t mk_item(input kind_t k, input logic [MaskW-1:0] mask,
                                    input logic cls, input logic hv, input logic gnd,
                                    input logic chg);
    item_t it;
    it.kind = k;
    it.cmd_sel = mask;
    it.relay_close = cls;
    it.hv_sensed = hv;
    it.gnd_sensed = gnd;
    it.charging = chg;
    return it;
  endfunction

  // Random content in every field; callers override what the kind needs
  function automatic item_t rand_fields(input kind_t k);
    return mk_item(k, MaskW'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom));
  endfunction

  function automatic void add_item(input item_t it, input bit has_exp, input result_t exp);
    stim_row_t row;
    row.op = ROW_ITEM;
    row.it = it;
    row.idx = '0;
    row.wdata = '0;
    row.has_exp = has_exp;
    row.exp = exp;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [CfgIdxW-1:0] idx, input logic [DelayW-1:0] d);
    stim_row_t row;
    row.op = ROW_CFG;
    row.it = '0;
    row.idx = idx;
    row.wdata = d;
    row.has_exp = 1'b0;
    row.exp = '0;
    dir_tab.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Enter and leave on a falling edge; the write enable is low again before the return
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [DelayW-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    if (idx == CFG_STEP_DELAY) begin
      step_delay = d;
    end else if (idx == CFG_RELAY_BIT) begin
      relay_bit = d[BitSelW-1:0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one transaction, hold it through stalls, predict on acceptance
  task automatic send_item(input item_t it, input bit has_exp, input result_t exp);
    result_t want;
    if (!tx_quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_cmd_sel <= it.cmd_sel;
    in_relay_close <= it.relay_close;
    in_hv_sensed <= it.hv_sensed;
    in_gnd_sensed <= it.gnd_sensed;
    in_charging <= it.charging;
    do @(posedge clk); while (in_stall);
    items_sent++;
    want = relay_predict(it);
    relay_exp_q.push_back(has_exp ? exp : want);
    @(negedge clk);
  endtask

  // Hold the input off until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (relay_exp_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Close, run the steps with sense updates and rare faults mixed in, open, wait out the report
  task automatic run_sequence();
    item_t it;
    int unsigned d;
    int unsigned n;
    int unsigned r;
    d = (step_delay == 0) ? 1 : step_delay;
    if (d > 20) begin
      d = 20;
    end
    it = rand_fields(KIND_CMD);
    it.cmd_sel[relay_bit] = 1'b1;
    it.relay_close = 1'b1;
    send_item(it, 1'b0, '0);
    n = 2 * d + $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 39);
      if (r == 0) begin
        send_item(rand_fields(KIND_FAULT), 1'b0, '0);
      end else if (r < 7) begin
        send_item(rand_fields(KIND_SENSE), 1'b0, '0);
      end else begin
        send_item(rand_fields(KIND_TICK), 1'b0, '0);
      end
    end
    it = rand_fields(KIND_CMD);
    it.cmd_sel[relay_bit] = 1'b1;
    it.relay_close = 1'b0;
    send_item(it, 1'b0, '0);
    n = d + $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(rand_fields(KIND_SENSE), 1'b0, '0);
      end else begin
        send_item(rand_fields(KIND_TICK), 1'b0, '0);
      end
    end
  endtask

  // Receiver: random stall bursts, plus one long hold when asked
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len != 0) begin
        hold = rx_hold_len;
        rx_hold_len = 0;
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : score
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_hv_drive, out_gnd_drive, out_open_gnd_first, out_report_state,
             out_report_hv, out_report_gnd, out_confirm_battery, out_busy_res};
      results_seen++;
      if (got.confirm_battery === 1'b1) begin
        confirms_seen++;
      end
      if (got.report_state === 1'b1) begin
        reports_seen++;
      end
      if (relay_exp_q.size() == 0) begin
        report_mismatch($sformatf("result %b with nothing expected", got));
      end else begin
        want = relay_exp_q.pop_front();
        for (int b = 7; b >= 0; b--) begin
          if (got[b] !== want[b]) begin
            report_mismatch($sformatf("result %0d: %s got %b want %b", results_seen,
                                      FIELD_NAMES[b], got[b], want[b]));
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Timeout: %0d results still expected", relay_exp_q.size());
    $display("battery_relay_sequencer_top verification failed");
    $finish;
  end

  initial begin
    logic [DelayW-1:0] wd;
    int unsigned start;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_TICK;
    in_cmd_sel = '0;
    in_relay_close = 1'b0;
    in_hv_sensed = 1'b0;
    in_gnd_sensed = 1'b0;
    in_charging = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_STEP_DELAY;
    cfg_wdata = '0;

    // Directed table. Expected bits: hv, gnd, gnd-first, report, rep hv, rep gnd,
    // confirm, busy. Rows with has_exp clear go to the predictor.
    add_item(mk_item(KIND_TICK, 16'h0000, 0, 0, 0, 0), 1, result_t'(8'b0000_0000));
    add_item(mk_item(KIND_SENSE, 16'h0000, 0, 1, 1, 0), 1, result_t'(8'b0000_0000));
    add_item(mk_item(KIND_FAULT, 16'hFFFF, 1, 0, 0, 1), 1, result_t'(8'b0011_1100));
    // selector misses the battery relay bit: nothing moves
    add_item(mk_item(KIND_CMD, 16'hFFFE, 1, 1, 1, 1), 1, result_t'(8'b0000_0000));
    add_cfg(CFG_STEP_DELAY, 16'd2);
    add_cfg(CFG_RELAY_BIT, 16'hFFFF);
    add_cfg(CFG_SPARE_A, 16'h0005);
    add_cfg(CFG_SPARE_B, 16'hFFFF);
    add_item(mk_item(KIND_CMD, 16'h8000, 1, 0, 0, 0), 1, result_t'(8'b0100_0001));
    add_item(mk_item(KIND_TICK, 16'hFFFF, 1, 1, 1, 1), 0, '0);
    add_item(mk_item(KIND_TICK, 16'h0000, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(KIND_SENSE, 16'hFFFF, 1, 1, 0, 1), 0, '0);
    add_item(mk_item(KIND_TICK, 16'h0000, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(KIND_TICK, 16'h0000, 0, 0, 0, 0), 0, '0);
    // close again with HV already on, then an open that replaces the pending step
    add_item(mk_item(KIND_CMD, 16'h8000, 1, 0, 0, 0), 0, '0);
    add_item(mk_item(KIND_CMD, 16'hFFFF, 0, 1, 1, 0), 0, '0);
    add_item(mk_item(KIND_TICK, 16'h0000, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(KIND_TICK, 16'h0000, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(KIND_CMD, 16'h8000, 0, 0, 0, 1), 0, '0);
    add_item(mk_item(KIND_FAULT, 16'h0000, 0, 0, 1, 0), 0, '0);
    add_cfg(CFG_STEP_DELAY, 16'd0);
    add_item(mk_item(KIND_CMD, 16'h8000, 1, 0, 0, 1), 0, '0);
    add_item(mk_item(KIND_TICK, 16'h0000, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(KIND_TICK, 16'h0000, 0, 0, 0, 0), 0, '0);
    add_item(mk_item(KIND_CMD, 16'h7FFF, 1, 0, 0, 0), 0, '0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        drain();
        cfg_write(dir_tab[i].idx, dir_tab[i].wdata);
      end else begin
        send_item(dir_tab[i].it, dir_tab[i].has_exp, dir_tab[i].exp);
      end
    end

    for (int p = 0; p < N_SETTINGS; p++) begin
      drain();
      cfg_write(CFG_STEP_DELAY, set_delay[p]);
      // upper bits of the relay bit write must be dropped
      wd = DelayW'($urandom);
      wd[BitSelW-1:0] = set_bit[p];
      cfg_write(CFG_RELAY_BIT, wd);
      tx_quiet = (p == N_SETTINGS - 1);
      rx_quiet = (p == N_SETTINGS - 1);
      if (p == 2) begin
        rx_hold_len = LONG_HOLD;
      end
      start = items_sent;
      while (items_sent - start < set_budget[p]) begin
        if ($urandom_range(0, 9) < 7) begin
          run_sequence();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_item(rand_fields(kind_t'($urandom_range(0, 3))), 1'b0, '0);
          end
        end
      end
    end
    drain();
    repeat (4) @(posedge clk);

    $display("Run covered %0d relay transactions over %0d register settings", items_sent,
             N_SETTINGS + 3);
    $display("  %0d results checked, %0d confirm pulses, %0d state reports, %0d mismatches",
             results_seen, confirms_seen, reports_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("battery_relay_sequencer_top verification clean");
    end else begin
      $display("battery_relay_sequencer_top verification failed");
    end
    $finish;
  end

endmodule
